/* sv/rlcm_pkg.sv */
// Shared types and constants for the running LCM accumulator.
package rlcm_pkg;

   // Fixed width of the numeric payload fields on both channels
   localparam int unsigned FIELD_BITS = 63;

   typedef logic [FIELD_BITS-1:0] field_type;

   // Fold sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

/* sv/rlcm_req_if.sv */
// Input channel: one number of a set plus its end-of-set mark.
interface rlcm_req_if;
   logic                valid;
   logic                ready;
   rlcm_pkg::field_type value;
   logic                last_of_set;

   modport source (output valid, output value, output last_of_set, input ready);
   modport sink   (input valid, input value, input last_of_set, output ready);
endinterface

/* sv/rlcm_rsp_if.sv */
// Result channel: the LCM of a finished set and its overflow flag.
interface rlcm_rsp_if;
   logic                valid;
   logic                ready;
   rlcm_pkg::field_type lcm;
   logic                overflow;

   modport source (output valid, output lcm, output overflow, input ready);
   modport sink   (input valid, input lcm, input overflow, output ready);
endinterface

/* sv/rlcm_alu.sv */
// Shared add/subtract unit; top result bit is carry on add, borrow on subtract.
module rlcm_alu #(
   parameter int unsigned WIDTH = 64
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   input  logic             sub,
   output logic [WIDTH:0]   res
);

   always_comb begin
      if (sub) begin
         res = {1'b0, opa} - {1'b0, opb};
      end else begin
         res = {1'b0, opa} + {1'b0, opb};
      end
   end

endmodule

/* sv/running_lcm_accumulator_unit.sv */
// Running LCM accumulator top level: sequencer, registers and the shared adder.
//
// Keeps a running least common multiple over sets of numbers. The first beat
// of a set loads the accumulator; each later beat x folds in as
// acc = (acc / gcd(acc, x)) * x, kept to VALUE_BITS bits with a sticky
// overflow flag. A zero on either side makes the accumulator 0. The beat
// marked last_of_set produces one result beat, after which the block clears
// for the next set. All arithmetic runs through a single VALUE_BITS+1 bit
// add/subtract unit under a small sequencer, and req_port is ready only when
// the sequencer is idle. Steps per beat:
//   - first beat of a set, or a zero operand: handled in the accepting cycle;
//   - a real fold: the accepting cycle, then a binary (Stein) gcd, one shift
//     or subtract per cycle, then a restoring divide and a shift-add
//     multiply; the gcd usually settles well before its worst case;
//   - a last beat then passes through the emit state to load the result
//     register, waiting there while an earlier result still waits; once
//     loaded it is held until the sink takes it, while the next set may
//     already start.
// Only the low VALUE_BITS bits of value are used; lcm is zero-extended.
module running_lcm_accumulator_unit #(
   parameter int unsigned VALUE_BITS = 63
) (
   input logic           clock,
   input logic           reset,
   rlcm_req_if.sink      req_port,
   rlcm_rsp_if.source    rsp_port
);

   localparam int unsigned ALU_BITS = VALUE_BITS + 1;
   localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

   // sequencer
   rlcm_pkg::state_type state_ff, state_in;

   // set state
   logic [VALUE_BITS-1:0] acc_ff, acc_in;        // running multiple
   logic                  started_ff, started_in;
   logic                  ovf_ff, ovf_in;        // sticky overflow of the set

   // working registers of one fold
   logic [VALUE_BITS-1:0] x_ff, x_in;            // item, later the multiplier
   logic                  last_ff, last_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;            // gcd operand, then divisor
   logic [VALUE_BITS-1:0] b_ff, b_in;            // gcd operand
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;        // dividend, quotient fills in
   logic [VALUE_BITS-1:0] rem_ff, rem_in;        // partial remainder
   logic [VALUE_BITS-1:0] p_ff, p_in;            // partial product
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_lcm_ff, rsp_lcm_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   // shared adder
   logic [ALU_BITS-1:0]   alu_a, alu_b;
   logic                  alu_sub;
   logic [ALU_BITS:0]     alu_res;

   logic [VALUE_BITS-1:0] x_new;
   logic                  req_take;
   logic                  slot_free;
   logic                  needs_fold;
   logic                  a_ge_b;

   rlcm_alu #(
      .WIDTH (ALU_BITS)
   ) u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .sub (alu_sub),
      .res (alu_res)
   );

   assign x_new      = req_port.value[VALUE_BITS-1:0];
   assign req_take   = req_port.valid && req_port.ready;
   assign slot_free  = !rsp_valid_ff || rsp_port.ready;
   assign needs_fold = started_ff && (acc_ff != '0) && (x_new != '0);
   assign a_ge_b     = a_ff >= b_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlcm_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               if (needs_fold) begin
                  state_in = rlcm_pkg::ST_GCD;
               end else if (req_port.last_of_set) begin
                  state_in = rlcm_pkg::ST_EMIT;
               end
            end
         end
         rlcm_pkg::ST_GCD: begin
            if (a_ff == b_ff) begin
               state_in = rlcm_pkg::ST_DIV;
            end
         end
         rlcm_pkg::ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = rlcm_pkg::ST_MUL;
            end
         end
         rlcm_pkg::ST_MUL: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = last_ff ? rlcm_pkg::ST_EMIT : rlcm_pkg::ST_IDLE;
            end
         end
         rlcm_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = rlcm_pkg::ST_IDLE;
            end
         end
         default: state_in = rlcm_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      acc_in     = acc_ff;
      started_in = started_ff;
      ovf_in     = ovf_ff;
      x_in       = x_ff;
      last_in    = last_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      p_in       = p_ff;
      cnt_in     = cnt_ff;
      rsp_lcm_in = rsp_lcm_ff;
      rsp_ovf_in = rsp_ovf_ff;
      alu_a      = '0;
      alu_b      = '0;
      alu_sub    = 1'b0;

      unique case (state_ff)
         rlcm_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               x_in    = x_new;
               last_in = req_port.last_of_set;
               if (!started_ff) begin
                  acc_in     = x_new;
                  ovf_in     = 1'b0;
                  started_in = 1'b1;
               end else if (!needs_fold) begin
                  acc_in = '0;            // zero operand, overflow untouched
               end else begin
                  a_in   = acc_ff;
                  b_in   = x_new;
                  dvd_in = acc_ff;
               end
            end
         end
         rlcm_pkg::ST_GCD: begin
            // binary gcd; common factors of two are stripped from the
            // dividend too, so acc/gcd comes out as (acc>>k)/odd part
            if (a_ff != b_ff) begin
               if (!a_ff[0] && !b_ff[0]) begin
                  a_in   = a_ff >> 1;
                  b_in   = b_ff >> 1;
                  dvd_in = dvd_ff >> 1;
               end else if (!a_ff[0]) begin
                  a_in = a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_in = b_ff >> 1;
               end else begin
                  alu_sub = 1'b1;
                  if (a_ge_b) begin
                     alu_a = {1'b0, a_ff};
                     alu_b = {1'b0, b_ff};
                     a_in  = alu_res[VALUE_BITS:1];
                  end else begin
                     alu_a = {1'b0, b_ff};
                     alu_b = {1'b0, a_ff};
                     b_in  = alu_res[VALUE_BITS:1];
                  end
               end
            end else begin
               rem_in = '0;
               cnt_in = '0;
            end
         end
         rlcm_pkg::ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            alu_sub = 1'b1;
            alu_a   = {rem_ff, dvd_ff[VALUE_BITS-1]};
            alu_b   = {1'b0, a_ff};
            if (!alu_res[ALU_BITS]) begin
               rem_in = alu_res[VALUE_BITS-1:0];
            end else begin
               rem_in = alu_a[VALUE_BITS-1:0];
            end
            dvd_in = {dvd_ff[VALUE_BITS-2:0], !alu_res[ALU_BITS]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               p_in   = '0;
               cnt_in = '0;
            end
         end
         rlcm_pkg::ST_MUL: begin
            // shift-add, multiplier MSB first; any bit pushed past the top
            // means the exact product no longer fits
            alu_a  = {1'b0, p_ff[VALUE_BITS-2:0], 1'b0};
            alu_b  = x_ff[VALUE_BITS-1] ? {1'b0, dvd_ff} : '0;
            p_in   = alu_res[VALUE_BITS-1:0];
            x_in   = {x_ff[VALUE_BITS-2:0], 1'b0};
            ovf_in = ovf_ff | p_ff[VALUE_BITS-1] | alu_res[VALUE_BITS];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               acc_in = alu_res[VALUE_BITS-1:0];
               cnt_in = '0;
            end
         end
         rlcm_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_lcm_in = acc_ff;
               rsp_ovf_in = ovf_ff;
               acc_in     = '0;
               started_in = 1'b0;
               ovf_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if ((state_ff == rlcm_pkg::ST_EMIT) && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_port.ready    = (state_ff == rlcm_pkg::ST_IDLE);
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.lcm      = rlcm_pkg::field_type'(rsp_lcm_ff);
   assign rsp_port.overflow = rsp_ovf_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlcm_pkg::ST_IDLE;
         acc_ff       <= '0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      last_ff    <= last_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      p_ff       <= p_in;
      rsp_lcm_ff <= rsp_lcm_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

`ifndef SYNTH
   // gcd operands never reach zero, else the loop would not terminate
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlcm_pkg::ST_GCD) |-> ((a_ff != '0) && (b_ff != '0)))
      else $error("gcd operand is zero");

   // partial remainder stays below the divisor throughout the divide
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlcm_pkg::ST_DIV) |-> (rem_ff < a_ff))
      else $error("partial remainder not below divisor");

   // a result beat leaves the set state cleared for the next set
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rlcm_pkg::ST_EMIT) && slot_free)
         |=> (!started_ff && (acc_ff == '0) && !ovf_ff && rsp_valid_ff))
      else $error("set state not cleared after result");

   // after a beat is taken the sequencer is idle, in the gcd or emitting
   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ((state_ff == rlcm_pkg::ST_IDLE) || (state_ff == rlcm_pkg::ST_GCD)
                    || (state_ff == rlcm_pkg::ST_EMIT)))
      else $error("unexpected state after accepting a beat");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the running LCM accumulator: directed and random sets of beats.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef rlcm_pkg::field_type field_type;

   // Mask for a VALUE_BITS-wide number held in 64 bits
   localparam bit [63:0] VALUE_MASK   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam field_type FIELD_MAX    = '1;
   localparam int        CYCLE_LIMIT  = 1_500_000;
   // Covers a worst-case fold plus loading the result register
   localparam int        SETTLE_CYCLES = 300;
   localparam int        DRAIN_LIMIT   = 20_000;

   typedef struct {
      field_type lcm;
      logic      overflow;
   } set_result_type;

   logic clock;
   logic reset;

   rlcm_req_if req_bus ();
   rlcm_rsp_if rsp_bus ();

   running_lcm_accumulator_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow of the block's set state
   bit [63:0]   lcm_acc;
   bit          set_open;
   bit          set_overflow;

   // Set results still owed by the block, oldest first
   set_result_type owed_results[$];

   int error_count;
   int cycle_count;
   int burst_left;

   // Result channel stall pattern
   int rx_run_left;
   int rx_stall_left;

   // ------------------------------------------------------------------
   // Clock, run limit
   // ------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop: a hung handshake ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // LCM predictor
   // ------------------------------------------------------------------
   function automatic bit [63:0] euclid_gcd(input bit [63:0] a, input bit [63:0] b);
      bit [63:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Fold one accepted beat into the shadow state; a last beat owes a result.
   function automatic void fold_beat(input field_type value, input logic last_of_set);
      bit [63:0]      x;
      bit [63:0]      g;
      bit [63:0]      q;
      set_result_type owed;
      x = {1'b0, value};
      if (!set_open) begin
         // first beat of a set just loads the accumulator
         lcm_acc      = x;
         set_overflow = 1'b0;
         set_open     = 1'b1;
      end else if (lcm_acc == 0 || x == 0) begin
         // zero on either side forces 0, sticky flag untouched
         lcm_acc = 0;
      end else begin
         g = euclid_gcd(lcm_acc, x);
         q = lcm_acc / g;
         if (q > VALUE_MASK / x)
            set_overflow = 1'b1;
         // keep going with the truncated product after an overflow
         lcm_acc = (q * x) & VALUE_MASK;
      end
      if (last_of_set) begin
         owed.lcm      = lcm_acc[62:0];
         owed.overflow = set_overflow;
         owed_results  = {owed_results, owed};
         lcm_acc      = 0;
         set_open     = 1'b0;
         set_overflow = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of back-to-back beats with random gaps between.
   // Valid stays high across a burst, so the next beat's data simply
   // replaces the accepted one at the following falling edge.
   // ------------------------------------------------------------------
   task automatic send_beat(input field_type value, input logic last_of_set);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.value       <= value;
      req_bus.last_of_set <= last_of_set;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      fold_beat(value, last_of_set);
      burst_left--;
      if (burst_left <= 0) begin
         // end of burst: drop valid, idle a while, then pick the next burst
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         if ($urandom_range(0, 7) == 0)
            burst_left = 40;   // a long stretch with no idling
         else
            burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic send_set(input field_type values[$]);
      foreach (values[i])
         send_beat(values[i], i == values.size() - 1);
   endtask

   // ------------------------------------------------------------------
   // Result sink: ready follows its own run/stall pattern, redrawn as it
   // runs out. Occasional long runs give stretches without back-pressure.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      logic rdy;
      if (rx_stall_left > 0) begin
         rdy = 1'b0;
         rx_stall_left--;
      end else if (rx_run_left > 0) begin
         rdy = 1'b1;
         rx_run_left--;
      end else begin
         if ($urandom_range(0, 5) == 0) begin
            rx_run_left   = 40;
            rx_stall_left = 0;
         end else begin
            rx_run_left   = $urandom_range(1, 10);
            rx_stall_left = $urandom_range(0, 6);
         end
         rdy = (rx_stall_left == 0);
      end
      rsp_bus.ready <= rdy;
   end

   // ------------------------------------------------------------------
   // Result checker: every accepted result beat against the oldest owed one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result beat lcm=%0d with nothing owed", rsp_bus.lcm));
         end else begin
            want = owed_results.pop_front();
            if (rsp_bus.lcm !== want.lcm)
               report_mismatch($sformatf("lcm got %0d want %0d", rsp_bus.lcm, want.lcm));
            if (rsp_bus.overflow !== want.overflow)
               report_mismatch($sformatf("overflow got %b want %b (lcm %0d)",
                                         rsp_bus.overflow, want.overflow, want.lcm));
         end
      end
   end

   // ------------------------------------------------------------------
   // Random operands: mostly numbers with shared small factors, so sets
   // build real multiples before overflowing; some full-width, zero, one,
   // powers of two and values near the top of the range.
   // ------------------------------------------------------------------
   function automatic field_type random_operand();
      bit [63:0] v;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         v = $urandom_range(1, 2000);
      end else if (pick < 62) begin
         v = 1;
         repeat ($urandom_range(1, 7)) begin
            case ($urandom_range(0, 5))
               0: v = v * 2;
               1: v = v * 3;
               2: v = v * 5;
               3: v = v * 7;
               4: v = v * 11;
               default: v = v * 13;
            endcase
         end
      end else if (pick < 80) begin
         v = {$urandom, $urandom} & VALUE_MASK;
      end else if (pick < 86) begin
         v = $urandom_range(0, 1);
      end else if (pick < 94) begin
         v = 64'd1 << $urandom_range(0, 62);
      end else begin
         v = VALUE_MASK - $urandom_range(0, 16);
      end
      return v[62:0];
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // A lone beat is its own LCM, never overflowed.
   task automatic test_single_beat_sets();
      send_set('{field_type'(0)});
      send_set('{field_type'(1)});
      send_set('{FIELD_MAX});
   endtask

   // Zero on the accumulator side and on the operand side.
   task automatic test_zero_operands();
      send_set('{field_type'(0), field_type'(5)});
      send_set('{field_type'(5), field_type'(0)});
      send_set('{field_type'(0), field_type'(0)});
   endtask

   // Ordinary folds with shared factors, and a unit operand against the top value.
   task automatic test_plain_folds();
      send_set('{field_type'(6), field_type'(4)});
      send_set('{field_type'(4), field_type'(6), field_type'(10)});
      send_set('{field_type'(1), FIELD_MAX});
   endtask

   // Overflow stays sticky while folding continues on the truncated value,
   // and survives a later zero operand.
   task automatic test_overflow();
      send_set('{field_type'(64'd1 << 62), field_type'(3), field_type'(2)});
      send_set('{FIELD_MAX, FIELD_MAX - field_type'(1), field_type'(0)});
   endtask

   // Random sets, mostly 2..5 beats, some single beats and some long runs.
   task automatic test_random_sets(input int beat_budget);
      field_type values[$];
      int        set_len;
      int        sent;
      sent = 0;
      while (sent < beat_budget) begin
         case ($urandom_range(0, 9))
            0:       set_len = 1;
            1:       set_len = $urandom_range(8, 20);
            default: set_len = $urandom_range(2, 5);
         endcase
         values.delete();
         repeat (set_len) values = {values, random_operand()};
         send_set(values);
         sent += set_len;
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      int waited;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.value       = '0;
      req_bus.last_of_set = 1'b0;
      rsp_bus.ready       = 1'b0;
      lcm_acc             = 0;
      set_open            = 1'b0;
      set_overflow        = 1'b0;
      error_count         = 0;
      cycle_count         = 0;
      burst_left          = 1;
      rx_run_left         = 0;
      rx_stall_left       = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_beat_sets();
      test_zero_operands();
      test_plain_folds();
      test_overflow();
      test_random_sets(750);

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, bounded, then let any trailing activity show up
      waited = 0;
      while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (owed_results.size() != 0)
         report_mismatch($sformatf("%0d set results never arrived", owed_results.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/rlcm_pkg.sv
sv/rlcm_req_if.sv
sv/rlcm_rsp_if.sv
sv/rlcm_alu.sv
sv/running_lcm_accumulator_unit.sv
tb/tb_top.sv
